### design/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, constants and the character map for the base64url encoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] MASK_HI6 = 8'hfc;
   localparam logic [7:0] MASK_LO2 = 8'h03;
   localparam logic [7:0] MASK_HI4 = 8'hf0;
   localparam logic [7:0] MASK_LO4 = 8'h0f;
   localparam logic [7:0] MASK_HI2 = 8'hc0;
   localparam logic [7:0] MASK_LO6 = 8'h3f;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_DASH    = 8'h2d;
   localparam logic [7:0] CHAR_UNDER   = 8'h5f;

   localparam logic [5:0] SEXTET_LOWER = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT = 6'd52;
   localparam logic [5:0] SEXTET_DASH  = 6'd62;
   localparam logic [5:0] SEXTET_UNDER = 6'd63;

   // one group of up to three bytes, zero-filled, ready for the back end
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] last_idx;
      logic       eom;
   } group_type;

   typedef struct packed {
      logic      push;
      group_type data;
   } queue_wr_type;

   typedef struct packed {
      logic      not_empty;
      logic      full;
      group_type data;
   } queue_rd_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] idx);
      logic [7:0] result;
      if (idx < SEXTET_LOWER) begin
         result = CHAR_UPPER_A + {2'b00, idx};
      end else if (idx < SEXTET_DIGIT) begin
         result = CHAR_LOWER_A + {2'b00, idx - SEXTET_LOWER};
      end else if (idx < SEXTET_DASH) begin
         result = CHAR_ZERO + {2'b00, idx - SEXTET_DIGIT};
      end else if (idx == SEXTET_DASH) begin
         result = CHAR_DASH;
      end else begin
         result = CHAR_UNDER;
      end
      return result;
   endfunction

endpackage

### design/b64u_front.sv
// ----------------------------------------------------------------------------
// b64u_front
// Gathers input bytes into groups of up to three and pushes each group when it is full or closed by end of message.
// ----------------------------------------------------------------------------
module b64u_front
   import b64u_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_data_byte,
   input  logic         req_end_of_message,
   input  logic         queue_full,
   output queue_wr_type queue_wr
);

   logic [1:0] count_ff, count_in;
   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic       accept;
   logic       store;
   group_type  group;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign store     = (count_ff < 2'd2) && !req_end_of_message;

   always_comb begin
      group.byte0    = 8'h00;
      group.byte1    = 8'h00;
      group.byte2    = 8'h00;
      group.eom      = req_end_of_message;
      group.last_idx = count_ff + 2'd1;
      case (count_ff)
         2'd0: begin
            group.byte0 = req_data_byte;
         end
         2'd1: begin
            group.byte0 = pend0_ff;
            group.byte1 = req_data_byte;
         end
         default: begin
            group.byte0    = pend0_ff;
            group.byte1    = pend1_ff;
            group.byte2    = req_data_byte;
            group.last_idx = 2'd3;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      if (accept) begin
         if (store) begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               pend0_in = req_data_byte;
            end else begin
               pend1_in = req_data_byte;
            end
         end else begin
            count_in = 2'd0;
         end
      end
   end

   assign queue_wr.push = accept && !store;
   assign queue_wr.data = group;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

endmodule

### design/b64u_queue.sv
// ----------------------------------------------------------------------------
// b64u_queue
// Short first-in first-out queue of groups between front and back end.
// ----------------------------------------------------------------------------
module b64u_queue
   import b64u_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type queue_wr,
   input  logic         pop,
   output queue_rd_type queue_rd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign queue_rd.not_empty = (count_ff != '0);
   assign queue_rd.full      = (count_ff == CNT_W'(DEPTH));
   assign queue_rd.data      = entry_ff[rd_ptr_ff];

   assign do_push = queue_wr.push && !queue_rd.full;
   assign do_pop  = pop && queue_rd.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= queue_wr.data;
      end
   end

endmodule

### design/b64u_back.sv
// ----------------------------------------------------------------------------
// b64u_back
// Takes groups from the queue and sends their characters one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module b64u_back
   import b64u_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  queue_rd_type queue_rd,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_char,
   output logic         rsp_last_char
);

   logic       busy_ff, busy_in;
   group_type  group_ff, group_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic       finish;
   logic [5:0] sextet;

   assign out_free = !valid_ff || !rsp_stall;
   assign finish   = busy_ff && out_free && (idx_ff == group_ff.last_idx);
   assign pop      = queue_rd.not_empty && (!busy_ff || finish);

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = 6'((group_ff.byte0 & MASK_HI6) >> 2);
         2'd1:    sextet = {group_ff.byte0[1:0] & MASK_LO2[1:0],
                            4'((group_ff.byte1 & MASK_HI4) >> 4)};
         2'd2:    sextet = {group_ff.byte1[3:0] & MASK_LO4[3:0],
                            2'((group_ff.byte2 & MASK_HI2) >> 6)};
         default: sextet = 6'(group_ff.byte2 & MASK_LO6);
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      group_in = group_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = busy_ff;
         if (busy_ff) begin
            char_in = sextet_char(sextet);
            last_in = group_ff.eom && (idx_ff == group_ff.last_idx);
            idx_in  = idx_ff + 2'd1;
         end
      end
      if (finish) begin
         busy_in = 1'b0;
      end
      if (pop) begin
         busy_in  = 1'b1;
         group_in = queue_rd.data;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      group_ff <= group_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

`ifndef ASSERT_OFF
   a_pop_only_done: assert property (@(posedge clock) disable iff (reset)
      (pop && busy_ff) |-> finish)
      else $error("group taken before current one is done");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= group_ff.last_idx))
      else $error("character index beyond group");

   a_group_held: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !finish) |=> $stable(group_ff))
      else $error("group changed while in progress");

   a_last_ends_group: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && out_free && group_ff.eom && idx_ff == group_ff.last_idx)
      |=> (valid_ff && last_ff))
      else $error("final character lost its last mark");
`endif

endmodule

### design/base64url_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64url_stream_encoder_core
// Unpadded URL-safe base64 encoder, one input byte per word in, one character
// per word out.
//
// The req_ channel carries a byte and an end-of-message flag. The rsp_
// channel carries one ASCII character per word, with rsp_last_char set on
// the final character of each message. A full group of three bytes gives
// four characters; a partial group closed by the flag gives two or three.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low.
// The byte that closes a group passes through the queue entry, the group
// register and the output register before its first character appears.
// Throughput: one character per cycle while rsp_stall is low, set by the single output register.
// The front end keeps taking bytes while groups wait in a queue of
// QUEUE_DEPTH entries; req_stall rises only when that queue is full, so a
// stall on rsp_ backs up through the queue and then onto req_.
// Reset clears the pending byte count, the queue and the output valid flag;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module base64url_stream_encoder_core
   import b64u_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         pop;

   b64u_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .queue_full         (queue_rd.full),
      .queue_wr           (queue_wr)
   );

   b64u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (pop),
      .queue_rd (queue_rd)
   );

   b64u_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_rd      (queue_rd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

### verif/base64url_stream_encoder_core_test.sv
// ----------------------------------------------------------------------------
// base64url_stream_encoder_core_test
// Self-checking bench for the unpadded base64url stream encoder. Bytes go in
// as whole messages, short directed ones first and then random lengths and
// contents. A local predictor keeps its own pending group and queues the
// characters each accepted byte must produce. Every character taken on rsp_
// is checked in order against that queue. The sender works in bursts with
// random gaps. The receiver runs without stalls, stalls at random, stalls on a
// rotating pattern or stalls in long runs, with the mode set for each phase.
// ----------------------------------------------------------------------------
module base64url_stream_encoder_core_test;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } enc_char_type;

   typedef enum int {RSP_FREE, RSP_RANDOM, RSP_PATTERN, RSP_BURSTY} rsp_mode_type;

   localparam logic [511:0] URL_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;

   enc_char_type expected_chars[$];
   enc_char_type check_want;
   logic [7:0]   group_bytes[2];
   int           group_count = 0;
   int           error_count = 0;
   int           burst_left = 0;
   int           gap_max = 0;
   int           burst_max = 8;
   rsp_mode_type rsp_mode = RSP_FREE;
   int           stall_run = 0;
   logic [15:0]  stall_pattern = 16'b1100_1010_0111_0001;

   base64url_stream_encoder_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_char      (rsp_last_char)
   );

   always #10 clock = ~clock;

   function automatic logic [7:0] url_char(input logic [5:0] idx);
      return URL_ALPHABET[(63 - int'(idx)) * 8 +: 8];
   endfunction

   task automatic predict_chars(input logic [7:0] data_in, input logic eom);
      logic [7:0] g[3];
      logic [5:0] sx[4];
      int have;
      int nchars;
      enc_char_type ec;
      have = (group_count > 2) ? 2 : group_count;
      if (have < 2 && !eom) begin
         group_bytes[have] = data_in;
         group_count = have + 1;
         return;
      end
      g[0] = 8'h00;
      g[1] = 8'h00;
      g[2] = 8'h00;
      for (int k = 0; k < have; k++) g[k] = group_bytes[k];
      g[have] = data_in;
      sx[0] = g[0][7:2];
      sx[1] = {g[0][1:0], g[1][7:4]};
      sx[2] = {g[1][3:0], g[2][7:6]};
      sx[3] = g[2][5:0];
      nchars = have + 2;
      for (int k = 0; k < nchars; k++) begin
         ec.code = url_char(sx[k]);
         ec.last = eom && (k == nchars - 1);
         expected_chars.push_back(ec);
      end
      group_count = 0;
   endtask

   task automatic send_word(input logic [7:0] data_in, input logic eom);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data_in;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_chars(data_in, eom);
      burst_left--;
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_random_messages(input int total_words);
      int sent;
      int len;
      logic [7:0] data_in;
      sent = 0;
      while (sent < total_words) begin
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
               0: data_in = 8'h00;
               1: data_in = 8'hff;
               default: data_in = 8'($urandom_range(0, 255));
            endcase
            send_word(data_in, k == len - 1);
         end
         sent += len;
      end
   endtask

   task automatic test_full_groups;
      gap_max  = 0;
      rsp_mode = RSP_FREE;
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hff, 1'b0);
      send_word(8'hff, 1'b0);
      send_word(8'hff, 1'b1);
      send_word(8'hfb, 1'b0);
      send_word(8'hef, 1'b0);
      send_word(8'hbe, 1'b1);
      send_word(8'h01, 1'b0);
      send_word(8'h23, 1'b0);
      send_word(8'h45, 1'b0);
      send_word(8'h67, 1'b1);
      wait_drained();
   endtask

   task automatic test_partial_groups;
      gap_max  = 3;
      rsp_mode = RSP_RANDOM;
      send_word(8'h00, 1'b1);
      send_word(8'hff, 1'b1);
      send_word(8'ha5, 1'b0);
      send_word(8'h5a, 1'b1);
      send_word(8'h80, 1'b0);
      send_word(8'h01, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'hff, 1'b0);
      send_word(8'hff, 1'b1);
      wait_drained();
   endtask

   task automatic test_back_to_back;
      gap_max  = 0;
      rsp_mode = RSP_FREE;
      send_random_messages(80);
      wait_drained();
   endtask

   task automatic test_random_idle;
      gap_max   = 4;
      burst_max = 10;
      rsp_mode  = RSP_RANDOM;
      send_random_messages(80);
      wait_drained();
   endtask

   task automatic test_pattern_stall;
      gap_max   = 2;
      burst_max = 5;
      rsp_mode  = RSP_PATTERN;
      send_random_messages(80);
      wait_drained();
   endtask

   task automatic test_bursty_stall;
      gap_max   = 6;
      burst_max = 16;
      rsp_mode  = RSP_BURSTY;
      send_random_messages(80);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else begin
         case (rsp_mode)
            RSP_FREE: rsp_stall <= 1'b0;
            RSP_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 30);
            RSP_PATTERN: begin
               rsp_stall     <= stall_pattern[0];
               stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
            default: begin
               if (stall_run == 0) begin
                  stall_run <= $urandom_range(1, 12);
                  rsp_stall <= 1'($urandom_range(0, 1));
               end else begin
                  stall_run <= stall_run - 1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual char %h last %b",
                     $time, rsp_out_char, rsp_last_char);
            error_count++;
         end else begin
            check_want = expected_chars.pop_front();
            if (rsp_out_char !== check_want.code) begin
               $display("%0t: out_char mismatch: expected %h, actual %h",
                        $time, check_want.code, rsp_out_char);
               error_count++;
            end
            if (rsp_last_char !== check_want.last) begin
               $display("%0t: last_char mismatch: expected %b, actual %b",
                        $time, check_want.last, rsp_last_char);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_groups();
      test_partial_groups();
      test_back_to_back();
      test_random_idle();
      test_pattern_stall();
      test_bursty_stall();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
design/b64u_pkg.sv
design/b64u_front.sv
design/b64u_queue.sv
design/b64u_back.sv
design/base64url_stream_encoder_core.sv
verif/base64url_stream_encoder_core_test.sv
